// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent, outside reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/ift_pkg.sv =====
// ----------------------------------------------------------------------------
// ift_pkg
// Widths, field kinds and grade limits for the impedance fuse trim block.
// ----------------------------------------------------------------------------
`default_nettype none

package ift_pkg;

  localparam int FUSE_W  = 7;
  localparam int KIND_W  = 2;
  localparam int VAL_W   = 6;
  localparam int CODE_W  = 5;
  localparam int GRADE_W = 4;

  // fuse word bit positions
  localparam int FUSE_VALID_BIT = 6;
  localparam int FUSE_DIR_BIT   = 5;

  localparam logic [KIND_W-1:0] KIND_DRVP  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DRVN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ODT_A = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ODT_B = 2'd3;

  localparam logic [VAL_W-1:0] NARROW_MASK = 6'h1f;

  // Weight is W_BASE + W_UNIT * value, every field bit weight being a
  // power-of-two multiple of W_UNIT; the grade thresholds are rescaled
  // onto m = code * (value + M_OFS) so no divide is needed.
  localparam int unsigned W_UNIT    = 2500;
  localparam int unsigned W_BASE    = 10000;
  localparam int unsigned DIV       = 1175;
  localparam int unsigned Q_TOP     = 749;
  localparam int unsigned Q_STEP    = 100;
  localparam int unsigned NUM_STEPS = 8;
  localparam int unsigned M_OFS     = W_BASE / W_UNIT;
  localparam int          M_OFS_W   = VAL_W + 1;
  localparam int          M_W       = CODE_W + M_OFS_W;

  typedef struct packed {
    logic [FUSE_W-1:0] fuse_word;
    logic [KIND_W-1:0] field_kind;
    logic [VAL_W-1:0]  field_value;
  } req_t;

  // Smallest m whose quotient exceeds the upper bound of grade idx.
  function automatic logic [M_W-1:0] grade_lim(input int unsigned idx);
    int unsigned q_max;
    q_max = Q_TOP - (NUM_STEPS - 1 - idx) * Q_STEP;
    return M_W'(((q_max + 1) * DIV + W_UNIT - 1) / W_UNIT);
  endfunction

endpackage

`default_nettype wire

// ===== sv/ift_in_reg.sv =====
// ----------------------------------------------------------------------------
// ift_in_reg
// Request capture register.
// ----------------------------------------------------------------------------
`default_nettype none

module ift_in_reg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        take,
  input  wire ift_pkg::req_t req_in,
  output logic             req_valid,
  output ift_pkg::req_t    req_out
);

  logic          valid_r;
  ift_pkg::req_t req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_r <= req_in;
    end
  end

  assign req_valid = valid_r;
  assign req_out   = req_r;

endmodule

`default_nettype wire

// ===== sv/ift_calc.sv =====
// ----------------------------------------------------------------------------
// ift_calc
// Grade lookup and field update, with the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ift_calc (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         req_valid,
  input  wire ift_pkg::req_t                req,
  output logic                              res_valid,
  output logic [ift_pkg::VAL_W-1:0]         res_new_value,
  output logic                              res_applied,
  output logic [ift_pkg::GRADE_W-1:0]       res_grade
);

  logic                          wide;
  logic [ift_pkg::VAL_W-1:0]     val;
  logic [ift_pkg::CODE_W-1:0]    code;
  logic [ift_pkg::M_OFS_W-1:0]   wsum;
  logic [ift_pkg::M_W-1:0]       m;
  logic [ift_pkg::GRADE_W-1:0]   cnt;
  logic                          fuse_ok;
  logic [ift_pkg::VAL_W-1:0]     stepped;

  logic                          valid_r;
  logic [ift_pkg::VAL_W-1:0]     new_value_r, new_value_nxt;
  logic                          applied_r;
  logic [ift_pkg::GRADE_W-1:0]   grade_r, grade_nxt;

  always_comb begin
    wide    = (req.field_kind == ift_pkg::KIND_DRVP) ||
              (req.field_kind == ift_pkg::KIND_DRVN);
    val     = wide ? req.field_value : (req.field_value & ift_pkg::NARROW_MASK);
    code    = req.fuse_word[ift_pkg::CODE_W-1:0];
    fuse_ok = req.fuse_word[ift_pkg::FUSE_VALID_BIT];
    wsum    = ift_pkg::M_OFS_W'(val) + ift_pkg::M_OFS_W'(ift_pkg::M_OFS);
    m       = ift_pkg::M_W'(code) * ift_pkg::M_W'(wsum);

    // grade = number of limits reached
    cnt = '0;
    for (int i = 0; i < int'(ift_pkg::NUM_STEPS); i++) begin
      cnt = cnt + ift_pkg::GRADE_W'(m >= ift_pkg::grade_lim(i));
    end

    if (req.fuse_word[ift_pkg::FUSE_DIR_BIT]) begin
      stepped = val + ift_pkg::VAL_W'(cnt);
    end else begin
      stepped = val - ift_pkg::VAL_W'(cnt);
    end
    if (!wide) begin
      stepped = stepped & ift_pkg::NARROW_MASK;
    end

    new_value_nxt = fuse_ok ? stepped : val;
    grade_nxt     = fuse_ok ? cnt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      new_value_r <= new_value_nxt;
      applied_r   <= fuse_ok;
      grade_r     <= grade_nxt;
    end
  end

  assign res_valid     = valid_r;
  assign res_new_value = new_value_r;
  assign res_applied   = applied_r;
  assign res_grade     = grade_r;

endmodule

`default_nettype wire

// ===== sv/impedance_fuse_trim.sv =====
// ----------------------------------------------------------------------------
// impedance_fuse_trim
// Trims one drive or termination code field from a fuse word.
// ----------------------------------------------------------------------------
// A request is taken on every cycle with start high (busy never rises), and
// its result appears for one cycle with out_valid high, after the capture
// register and then the grade logic, which holds a single 5x7-bit multiply
// and eight compares, into the result register. The
// receiver cannot stall, so out_valid must be sampled on the cycle it is high.
`default_nettype none

`include "assert_macros.svh"

module impedance_fuse_trim (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [ift_pkg::FUSE_W-1:0]    in_fuse_word,
  input  wire logic [ift_pkg::KIND_W-1:0]    in_field_kind,
  input  wire logic [ift_pkg::VAL_W-1:0]     in_field_value,
  output logic                               out_valid,
  output logic [ift_pkg::VAL_W-1:0]          out_new_value,
  output logic                               out_applied,
  output logic [ift_pkg::GRADE_W-1:0]        out_grade
);

  ift_pkg::req_t req_in;
  ift_pkg::req_t req_q;
  logic          req_valid;
  logic          take;

  assign busy  = 1'b0;
  assign take  = start && !busy;
  assign req_in = '{fuse_word: in_fuse_word, field_kind: in_field_kind,
                    field_value: in_field_value};

  ift_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .req_in    (req_in),
    .req_valid (req_valid),
    .req_out   (req_q)
  );

  ift_calc u_calc (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req_valid),
    .req           (req_q),
    .res_valid     (out_valid),
    .res_new_value (out_new_value),
    .res_applied   (out_applied),
    .res_grade     (out_grade)
  );

  `ASSERT_IMPLY(a_no_spurious, clk, rst_n, out_valid, $past(start, 2), "result without request")
  `ASSERT_IMPLY(a_applied, clk, rst_n, out_valid, out_applied == $past(in_fuse_word[6], 2), "applied mismatch")
  `ASSERT_IMPLY(a_idle_grade, clk, rst_n, out_valid && !out_applied, out_grade == '0, "grade without fuse")
  `ASSERT_CLK(a_narrow, clk, rst_n, !(out_valid && $past(in_field_kind[1], 2)) || !out_new_value[5], "narrow field overflow")

endmodule

`default_nettype wire
